// ===== rtl/cbcb_pkg.sv =====
// ----------------------------------------------------------------------------
// cbcb_pkg: shared types, constants and functions
// Widths, divider geometry and the boost arithmetic used by all modules.
// ----------------------------------------------------------------------------
package cbcb_pkg;

  localparam int unsigned MAX_WIDTH   = 4096;
  localparam int unsigned REG_W       = 13;
  localparam int unsigned X_W         = 12;
  localparam int unsigned CH_W        = 8;
  localparam int unsigned IDX_W       = 2;
  localparam int unsigned REM_W       = $clog2(MAX_WIDTH) + 1;
  localparam int unsigned DVD_W       = X_W + $clog2(MAX_WIDTH);
  localparam int unsigned DIV_STEPS   = 4;
  localparam int unsigned DIV_STAGES  = (DVD_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int unsigned IN_TDATA_W  = ((X_W + 3 * CH_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((3 * CH_W + 7) / 8) * 8;

  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH = 2'd0;
  localparam logic [IDX_W-1:0] REG_BAND_COUNT  = 2'd1;

  // Band index mod 3 picks the boosted channel.
  localparam logic [1:0] SEL_RED   = 2'd0;
  localparam logic [1:0] SEL_GREEN = 2'd1;
  localparam logic [1:0] SEL_BLUE  = 2'd2;

  localparam logic [CH_W-1:0] CH_MAX = {CH_W{1'b1}};

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_t;

  typedef struct packed {
    logic             valid;
    logic [REM_W-1:0] rem;
    logic [DVD_W-1:0] dvd;
    logic [1:0]       qmod;
    pix_t             pix;
  } div_t;

  // Append one quotient bit to a running quotient held mod 3.
  function automatic logic [1:0] mod3_step(input logic [1:0] qm, input logic qbit);
    logic [2:0] v;
    logic [1:0] r;
    v = {qm, qbit};
    case (v)
      3'd0:    r = 2'd0;
      3'd1:    r = 2'd1;
      3'd2:    r = 2'd2;
      3'd3:    r = 2'd0;
      3'd4:    r = 2'd1;
      3'd5:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  // floor(3v/2) saturated at full scale.
  function automatic logic [CH_W-1:0] boost(input logic [CH_W-1:0] v);
    logic [CH_W:0] t;
    t = {1'b0, v} + {2'b00, v[CH_W-1:1]};
    return t[CH_W] ? CH_MAX : t[CH_W-1:0];
  endfunction

endpackage

// ===== rtl/cbcb_cfg.sv =====
// ----------------------------------------------------------------------------
// cbcb_cfg: configuration registers
// Hold image width and band count, clamped into 1..MAX_WIDTH on write.
// ----------------------------------------------------------------------------
module cbcb_cfg
  import cbcb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [IDX_W-1:0] wr_index_i,
  input  logic [REG_W-1:0] wr_data_i,
  output logic [REG_W-1:0] width_o,
  output logic [REG_W-1:0] bands_o
);

  logic [REG_W-1:0] width_q, width_d;
  logic [REG_W-1:0] bands_q, bands_d;
  logic [REG_W-1:0] clamped;

  always_comb begin
    if (wr_data_i == '0) begin
      clamped = REG_W'(1);
    end else if (wr_data_i > REG_W'(MAX_WIDTH)) begin
      clamped = REG_W'(MAX_WIDTH);
    end else begin
      clamped = wr_data_i;
    end
    width_d = width_q;
    bands_d = bands_q;
    if (wr_en_i) begin
      case (wr_index_i)
        REG_IMAGE_WIDTH: width_d = clamped;
        REG_BAND_COUNT:  bands_d = clamped;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= REG_W'(1);
      bands_q <= REG_W'(1);
    end else begin
      width_q <= width_d;
      bands_q <= bands_d;
    end
  end

  assign width_o = width_q;
  assign bands_o = bands_q;

endmodule

// ===== rtl/cbcb_div_stage.sv =====
// ----------------------------------------------------------------------------
// cbcb_div_stage: one stage of the band divider
// Retire DIV_STEPS quotient bits by restoring division, keep quotient mod 3.
// ----------------------------------------------------------------------------
module cbcb_div_stage
  import cbcb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic [REG_W-1:0] width_i,
  input  div_t             in_i,
  output div_t             out_o
);

  logic             valid_q;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [1:0]       qmod_q, qmod_d;
  pix_t             pix_q;

  always_comb begin
    logic [REM_W:0] trial;
    logic [REM_W:0] divisor;
    divisor = (REM_W + 1)'(width_i);
    rem_d   = in_i.rem;
    dvd_d   = in_i.dvd;
    qmod_d  = in_i.qmod;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial = {rem_d, dvd_d[DVD_W-1]};
      dvd_d = {dvd_d[DVD_W-2:0], 1'b0};
      if (trial >= divisor) begin
        trial  = trial - divisor;
        qmod_d = mod3_step(qmod_d, 1'b1);
      end else begin
        qmod_d = mod3_step(qmod_d, 1'b0);
      end
      rem_d = trial[REM_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      rem_q  <= rem_d;
      dvd_q  <= dvd_d;
      qmod_q <= qmod_d;
      pix_q  <= in_i.pix;
    end
  end

  assign out_o = {valid_q, rem_q, dvd_q, qmod_q, pix_q};

endmodule

// ===== rtl/cbcb_boost.sv =====
// ----------------------------------------------------------------------------
// cbcb_boost: channel boost and output register
// Boost the channel picked by band mod 3 and hold the result beat.
// ----------------------------------------------------------------------------
module cbcb_boost
  import cbcb_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  adv_i,
  input  div_t  in_i,
  output logic  valid_o,
  output pix_t  pix_o
);

  logic valid_q;
  pix_t pix_q, pix_d;

  always_comb begin
    pix_d = in_i.pix;
    case (in_i.qmod)
      SEL_RED:   pix_d.red   = boost(in_i.pix.red);
      SEL_GREEN: pix_d.green = boost(in_i.pix.green);
      SEL_BLUE:  pix_d.blue  = boost(in_i.pix.blue);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pix_q <= pix_d;
    end
  end

  assign valid_o = valid_q;
  assign pix_o   = pix_q;

endmodule

// ===== rtl/column_band_channel_boost.sv =====
// ----------------------------------------------------------------------------
// column_band_channel_boost: per-pixel channel boost by vertical band
// Throughput: one pixel per cycle while the output is not stalled; the
//   pipeline is the band product register, then the 6-stage divider (4
//   quotient bits per stage), then the boost output register.
// Reset (rst_ni low, asynchronous): all stage valid bits clear, image_width
//   and band_count return to 1. No clearing pass; input is taken at once.
// ----------------------------------------------------------------------------
module column_band_channel_boost
  import cbcb_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // input pixel stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [11:0] x_position, [19:12] blue_in, [27:20] green_in, [35:28] red_in,
  // [39:36] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // output pixel stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [7:0] blue_out, [15:8] green_out, [23:16] red_out
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // configuration writes: index 0 image_width, index 1 band_count
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [IDX_W-1:0]       cfg_index_i,
  input  logic [REG_W-1:0]       cfg_data_i
);

  logic [REG_W-1:0] width;
  logic [REG_W-1:0] bands;
  logic             adv;
  logic             out_valid;
  pix_t             out_pix;

  // Stage 0 is the product register; stages 1..DIV_STAGES are divider stages.
  div_t stage_s [0:DIV_STAGES];

  logic             s0_valid_q;
  logic [DVD_W-1:0] s0_dvd_q, s0_dvd_d;
  pix_t             s0_pix_q;

  logic [X_W-1:0] in_x;
  pix_t           in_pix;

  // Unpack the input beat.
  assign in_x         = s_axis_tdata[X_W-1:0];
  assign in_pix.blue  = s_axis_tdata[X_W +: CH_W];
  assign in_pix.green = s_axis_tdata[X_W + CH_W +: CH_W];
  assign in_pix.red   = s_axis_tdata[X_W + 2*CH_W +: CH_W];

  // Configuration is always taken; software must write it only while idle (not enforced here).
  assign cfg_ready_o = 1'b1;

  cbcb_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .width_o    (width),
    .bands_o    (bands)
  );

  // Whole pipeline advances together; it only holds when the output beat
  // is stuck, so bubbles never stop input while the output is free.
  assign adv           = !out_valid || m_axis_tready;
  assign s_axis_tready = adv;

  // Band numerator x * bands; the product fits DVD_W bits since bands is
  // clamped to MAX_WIDTH and x stays below MAX_WIDTH.
  assign s0_dvd_d = DVD_W'(in_x) * DVD_W'(bands);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (adv) begin
      s0_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_dvd_q <= s0_dvd_d;
      s0_pix_q <= in_pix;
    end
  end

  // Start the division with an empty remainder and a zero quotient.
  assign stage_s[0] = {s0_valid_q, {REM_W{1'b0}}, s0_dvd_q, SEL_RED, s0_pix_q};

  // Divide by image_width, tracking only the quotient mod 3.
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    cbcb_div_stage u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .width_i (width),
      .in_i    (stage_s[g]),
      .out_o   (stage_s[g+1])
    );
  end

  cbcb_boost u_boost (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .in_i    (stage_s[DIV_STAGES]),
    .valid_o (out_valid),
    .pix_o   (out_pix)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_pix.red, out_pix.green, out_pix.blue};

endmodule

// ===== rtl/cbcb_checker.sv =====
// ----------------------------------------------------------------------------
// cbcb_checker: port-level checks for column_band_channel_boost
// Watch stream and config ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module cbcb_checker
  import cbcb_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   cfg_ready_o
);

  // Hold a stalled result beat.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // Accept input whenever the output register is free.
  a_ready_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output");

  // Back-pressure reaches the input in the same cycle.
  a_stall_backs_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while output stalled");

  // Configuration writes are never refused.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config port not ready");

endmodule

bind column_band_channel_boost cbcb_checker u_cbcb_checker (.*);
